FILE: hdl/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

	localparam int DEF_MAX_BLOCKS   = 256;
	localparam int DEF_ADDRESS_BITS = 32;

	localparam int SIZE_W     = 16;
	localparam int COUNT_W    = 9;
	localparam int ADDR_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE  = 16'd16;
	localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = 9'd256;
	localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd4096;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_MISMATCH  = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FREED     = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NULL      = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_BLOCK_SIZE  = 2'd0,
		REG_BLOCK_COUNT = 2'd1,
		REG_POOL_BASE   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_WAIT = 2'd2,
		S_EXEC = 2'd3
	} state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  block_size;
		logic [COUNT_W-1:0] block_count;
		logic [ADDR_W-1:0]  pool_base;
		logic               base_wr;
		logic [ADDR_W-1:0]  base_new;
	} cfg_t;

endpackage

FILE: hdl/fbpa_if.sv
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [fbpa_pkg::SIZE_W-1:0] request_size;
	logic [fbpa_pkg::ADDR_W-1:0] release_address;

	modport source (output valid, output mode, output request_size,
		output release_address, input ready);
	modport sink (input valid, input mode, input request_size,
		input release_address, output ready);
endinterface

interface fbpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fbpa_pkg::ADDR_W-1:0]   block_address;
	logic [fbpa_pkg::STATUS_W-1:0] status;

	modport source (output valid, output block_address, output status, input ready);
	modport sink (input valid, input block_address, input status, output ready);
endinterface

FILE: hdl/fbpa_cfg.sv
// APB register file holding block size, block count and pool base.
module fbpa_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output fbpa_pkg::cfg_t                    cfg
);

	logic [fbpa_pkg::SIZE_W-1:0]  block_size_q;
	logic [fbpa_pkg::COUNT_W-1:0] block_count_q;
	logic [fbpa_pkg::ADDR_W-1:0]  pool_base_q;
	fbpa_pkg::reg_idx_t           idx;
	logic                         wr;

	assign pready = 1'b1;
	assign idx    = fbpa_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= fbpa_pkg::RST_BLOCK_SIZE;
			block_count_q <= fbpa_pkg::RST_BLOCK_COUNT;
			pool_base_q   <= fbpa_pkg::RST_POOL_BASE;
		end else if (wr) begin
			case (idx)
				fbpa_pkg::REG_BLOCK_SIZE:  block_size_q  <= pwdata[fbpa_pkg::SIZE_W-1:0];
				fbpa_pkg::REG_BLOCK_COUNT: block_count_q <= pwdata[fbpa_pkg::COUNT_W-1:0];
				fbpa_pkg::REG_POOL_BASE:   pool_base_q   <= pwdata[fbpa_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			fbpa_pkg::REG_BLOCK_SIZE:  prdata = fbpa_pkg::APB_DATA_W'(block_size_q);
			fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::APB_DATA_W'(block_count_q);
			fbpa_pkg::REG_POOL_BASE:   prdata = fbpa_pkg::APB_DATA_W'(pool_base_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.block_size  = block_size_q;
		cfg.block_count = block_count_q;
		cfg.pool_base   = pool_base_q;
		cfg.base_wr     = wr && (idx == fbpa_pkg::REG_POOL_BASE);
		cfg.base_new    = pwdata[fbpa_pkg::ADDR_W-1:0];
	end

endmodule

FILE: hdl/fbpa_ctrl.sv
// Controller state machine sequencing one request through the datapath.
module fbpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output fbpa_pkg::cmd_t cmd
);

	fbpa_pkg::state_t state_q;
	fbpa_pkg::state_t state_d;
	logic             out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			fbpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = fbpa_pkg::S_READ;
				end
			end
			fbpa_pkg::S_READ: begin
				cmd.read = 1'b1;
				state_d  = fbpa_pkg::S_WAIT;
			end
			fbpa_pkg::S_WAIT: begin
				state_d = fbpa_pkg::S_EXEC;
			end
			fbpa_pkg::S_EXEC: begin
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = fbpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fbpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/fbpa_dp.sv
// Datapath with the free stack memory, bump pointer and pool range check.
module fbpa_dp #(
	parameter int MAX_BLOCKS   = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int ADDRESS_BITS = fbpa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fbpa_pkg::cfg_t                    cfg,
	input  fbpa_pkg::cmd_t                    cmd,
	input  logic                              mode,
	input  logic [fbpa_pkg::SIZE_W-1:0]       request_size,
	input  logic [fbpa_pkg::ADDR_W-1:0]       release_address,
	output logic [fbpa_pkg::ADDR_W-1:0]       block_address,
	output logic [fbpa_pkg::STATUS_W-1:0]     status,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]   stack_top
);

	localparam int AB     = ADDRESS_BITS;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int EC_W   = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;
	localparam int SPAN_W = fbpa_pkg::SIZE_W + CNT_W;
	localparam int LIM_W  = (SPAN_W > AB) ? SPAN_W : AB;

	logic [AB-1:0]              mem [MAX_BLOCKS];

	logic                       mode_q;
	logic [fbpa_pkg::SIZE_W-1:0] req_q;
	logic [AB-1:0]              rel_q;
	logic [AB-1:0]              rd_q;
	logic [SPAN_W-1:0]          span_q;
	logic [LIM_W-1:0]           lim_q;
	logic [CNT_W-1:0]           eff_q;
	logic [CNT_W-1:0]           top_q;
	logic [AB-1:0]              nf_q;
	logic [fbpa_pkg::ADDR_W-1:0] addr_q;
	fbpa_pkg::status_t          status_q;

	logic [CNT_W-1:0]           eff_c;
	logic [AB-1:0]              base_a;
	logic [AB-1:0]              room;
	logic [LIM_W-1:0]           lim_c;
	logic [CNT_W-1:0]           top_m1;
	logic [AB-1:0]              sel;
	logic [AB-1:0]              off;
	logic                       in_pool;
	logic                       pop;
	logic                       push;
	logic                       bump;
	logic [AB-1:0]              addr_c;
	fbpa_pkg::status_t          status_c;

	assign block_address = addr_q;
	assign status        = status_q;
	assign stack_top     = top_q;

	assign eff_c  = (EC_W'(cfg.block_count) > EC_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		: CNT_W'(cfg.block_count);
	assign base_a = AB'(cfg.pool_base);
	assign room   = {AB{1'b0}} - base_a;
	assign lim_c  = (base_a == {AB{1'b0}}) ? {LIM_W{1'b0}}
		: ((LIM_W'(span_q) < LIM_W'(room)) ? LIM_W'(span_q) : LIM_W'(room));
	assign top_m1 = top_q - CNT_W'(1);

	assign sel     = mode_q ? rel_q : nf_q;
	assign off     = sel - base_a;
	assign in_pool = LIM_W'(off) < lim_q;

	always_comb begin
		pop      = 1'b0;
		push     = 1'b0;
		bump     = 1'b0;
		addr_c   = {AB{1'b0}};
		status_c = fbpa_pkg::ST_EXHAUSTED;
		if (!mode_q) begin
			if (req_q != cfg.block_size) begin
				status_c = fbpa_pkg::ST_MISMATCH;
			end else if (top_q != {CNT_W{1'b0}}) begin
				pop      = 1'b1;
				addr_c   = rd_q;
				status_c = fbpa_pkg::ST_ALLOCATED;
			end else if (in_pool) begin
				bump     = 1'b1;
				addr_c   = nf_q;
				status_c = fbpa_pkg::ST_ALLOCATED;
			end else begin
				status_c = fbpa_pkg::ST_EXHAUSTED;
			end
		end else begin
			if (rel_q == {AB{1'b0}}) begin
				status_c = fbpa_pkg::ST_NULL;
			end else if (!in_pool) begin
				status_c = fbpa_pkg::ST_OUTSIDE;
			end else if (top_q >= eff_q) begin
				status_c = fbpa_pkg::ST_FULL;
			end else begin
				push     = 1'b1;
				status_c = fbpa_pkg::ST_FREED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			nf_q  <= AB'(fbpa_pkg::RST_POOL_BASE);
		end else if (cfg.base_wr) begin
			top_q <= '0;
			nf_q  <= AB'(cfg.base_new);
		end else if (cmd.exec) begin
			if (pop) begin
				top_q <= top_m1;
			end else if (push) begin
				top_q <= top_q + CNT_W'(1);
			end
			if (bump) begin
				nf_q <= nf_q + AB'(cfg.block_size);
			end
		end
	end

	always_ff @(posedge clk) begin
		eff_q  <= eff_c;
		span_q <= SPAN_W'(cfg.block_size) * SPAN_W'(eff_c);
		lim_q  <= lim_c;
		if (cmd.load) begin
			mode_q <= mode;
			req_q  <= request_size;
			rel_q  <= AB'(release_address);
		end
		if (cmd.read) begin
			rd_q <= mem[top_m1[IDX_W-1:0]];
		end
		if (cmd.exec && push) begin
			mem[top_q[IDX_W-1:0]] <= rel_q;
		end
		if (cmd.exec) begin
			addr_q   <= fbpa_pkg::ADDR_W'(addr_c);
			status_q <= status_c;
		end
	end

endmodule

FILE: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: registers, controller and datapath.
// A request word is taken only while idle; the execute step registers its response word.
// The four steps are accept, free stack memory read, wait, and execute.
// The response register lets the next request be taken while a response waits.
// Reset clears the stack top and loads the bump pointer with the reset pool base.
// The free stack memory is not cleared; only written entries are ever used.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS   = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int ADDRESS_BITS = fbpa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	fbpa_req_if.sink                          req,
	fbpa_rsp_if.source                        rsp
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	fbpa_pkg::cfg_t   cfg;
	fbpa_pkg::cmd_t   cmd;
	logic             in_ready;
	logic             out_valid;
	logic [CNT_W-1:0] stack_top;

	fbpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	fbpa_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.mode            (req.mode),
		.request_size    (req.request_size),
		.release_address (req.release_address),
		.block_address   (rsp.block_address),
		.status          (rsp.status),
		.stack_top       (stack_top)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an earlier request is in progress");

	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(req.valid && req.ready, 4))
		else $error("response word appeared without a matching request");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_top <= CNT_W'(MAX_BLOCKS))
		else $error("free stack top beyond its depth");

endmodule

FILE: tb/fixed_block_pool_allocator_test.sv
// Self-checking testbench for the fixed block pool allocator: directed and random requests.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
	import fbpa_pkg::*;

	localparam int   STACK_DEPTH = DEF_MAX_BLOCKS;
	localparam int   CYCLE_LIMIT = 200000;
	localparam logic MODE_ALLOC  = 1'b0;
	localparam logic MODE_FREE   = 1'b1;

	typedef struct {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
	} alloc_result_t;

	class pool_scoreboard;
		logic [SIZE_W-1:0]  block_size;
		logic [COUNT_W-1:0] block_count;
		logic [ADDR_W-1:0]  pool_base;
		logic [ADDR_W-1:0]  freed_blocks [STACK_DEPTH];
		int unsigned        stack_top;
		logic [ADDR_W-1:0]  next_fresh;
		alloc_result_t      awaited [$];
		int                 errors;
		int                 requests;
		int                 responses;
		int                 outcome_count [8];

		function new();
			block_size  = RST_BLOCK_SIZE;
			block_count = RST_BLOCK_COUNT;
			pool_base   = RST_POOL_BASE;
			stack_top   = 0;
			next_fresh  = RST_POOL_BASE;
			errors      = 0;
			requests    = 0;
			responses   = 0;
			foreach (outcome_count[i]) outcome_count[i] = 0;
		endfunction

		function int unsigned effective_count();
			return (block_count > STACK_DEPTH) ? STACK_DEPTH : block_count;
		endfunction

		function longint unsigned pool_span();
			longint unsigned span;
			longint unsigned room;
			span = 64'(block_size) * 64'(effective_count());
			room = 64'h1_0000_0000 - 64'(pool_base);
			if (pool_base == '0) return 0;
			return (span < room) ? span : room;
		endfunction

		function bit in_pool(logic [ADDR_W-1:0] a);
			logic [ADDR_W-1:0] offset;
			offset = a - pool_base;
			return 64'(offset) < pool_span();
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			case (idx)
				REG_BLOCK_SIZE:  block_size = value[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count = value[COUNT_W-1:0];
				REG_POOL_BASE: begin
					pool_base  = value[ADDR_W-1:0];
					next_fresh = value[ADDR_W-1:0];
					stack_top  = 0;
				end
				default: ;
			endcase
		endfunction

		function alloc_result_t take_request(logic mode, logic [SIZE_W-1:0] size,
			logic [ADDR_W-1:0] rel);
			alloc_result_t res;
			res.block_address = '0;
			if (mode == MODE_ALLOC) begin
				if (size != block_size)
					res.status = ST_MISMATCH;
				else if (stack_top != 0) begin
					stack_top--;
					res.block_address = freed_blocks[stack_top % STACK_DEPTH];
					res.status = ST_ALLOCATED;
				end else if (in_pool(next_fresh)) begin
					res.block_address = next_fresh;
					next_fresh = next_fresh + block_size;
					res.status = ST_ALLOCATED;
				end else
					res.status = ST_EXHAUSTED;
			end else begin
				if (rel == '0)
					res.status = ST_NULL;
				else if (!in_pool(rel))
					res.status = ST_OUTSIDE;
				else if (stack_top >= effective_count())
					res.status = ST_FULL;
				else begin
					freed_blocks[stack_top % STACK_DEPTH] = rel;
					stack_top++;
					res.status = ST_FREED;
				end
			end
			requests++;
			awaited.push_back(res);
			return res;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task check_response(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status);
			alloc_result_t want;
			responses++;
			if (!$isunknown(status)) outcome_count[status]++;
			if (awaited.size() == 0) begin
				report($sformatf("response word %0d arrived with nothing awaited", responses));
				return;
			end
			want = awaited.pop_front();
			if (status !== want.status)
				report($sformatf("response word %0d: status %0d, expected %0d",
					responses, status, want.status));
			if (addr !== want.block_address)
				report($sformatf("response word %0d: block_address %h, expected %h",
					responses, addr, want.block_address));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	pool_scoreboard    sb;
	bit                steady = 1'b0;
	bit                hold_request = 1'b0;
	int unsigned       cycle_count = 0;
	int                settings_run = 0;
	logic [ADDR_W-1:0] live_blocks [$];

	fixed_block_pool_allocator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.block_address, rsp_ch.status);
			if (hold_request) begin
				hold_left = 300;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size,
		input logic [ADDR_W-1:0] rel, output alloc_result_t outcome);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99) < 27) gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.mode            <= mode;
		req_ch.request_size    <= size;
		req_ch.release_address <= rel;
		do @(posedge clk); while (!req_ch.ready);
		outcome = sb.take_request(mode, size, rel);
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] mask;
		logic [APB_DATA_W-1:0] seen;
		mask = '1;
		if (idx == REG_BLOCK_SIZE) mask = (32'd1 << SIZE_W) - 1;
		if (idx == REG_BLOCK_COUNT) mask = (32'd1 << COUNT_W) - 1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if ((seen & mask) != (value & mask))
			sb.report($sformatf("register %0d reads %h, written %h", idx, seen, value));
	endtask

	task automatic program_pool(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count,
		input logic [ADDR_W-1:0] base);
		drain_responses();
		write_register(REG_BLOCK_SIZE, 32'(size));
		write_register(REG_BLOCK_COUNT, 32'(count));
		write_register(REG_POOL_BASE, 32'(base));
		live_blocks.delete();
		settings_run++;
	endtask

	task automatic run_random(input int n, input int alloc_pct, input int free_pct,
		input int pause_at, input bit hold);
		alloc_result_t     outcome;
		logic [ADDR_W-1:0] addr;
		longint unsigned   span;
		int                r;
		int                pick;
		if (hold) hold_request = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) drain_responses();
			span = sb.pool_span();
			r = $urandom_range(99);
			if (r < alloc_pct || (r < alloc_pct + free_pct && live_blocks.size() == 0))
				send_request(MODE_ALLOC, sb.block_size, $urandom, outcome);
			else if (r < alloc_pct + free_pct) begin
				pick = $urandom_range(live_blocks.size() - 1);
				addr = live_blocks[pick];
				live_blocks.delete(pick);
				send_request(MODE_FREE, SIZE_W'($urandom), addr, outcome);
			end else begin
				case ($urandom_range(4))
					0: send_request(MODE_ALLOC, SIZE_W'($urandom), $urandom, outcome);
					1: send_request(MODE_FREE, SIZE_W'($urandom), '0, outcome);
					2: send_request(MODE_FREE, SIZE_W'($urandom), $urandom, outcome);
					3: begin
						addr = (span == 0) ? $urandom
							: sb.pool_base + $urandom_range(32'(span - 1));
						send_request(MODE_FREE, SIZE_W'($urandom), addr, outcome);
					end
					default: begin
						pick = $urandom_range(3);
						addr = sb.pool_base;
						if (pick == 0) addr = sb.pool_base - 1;
						if (pick == 1) addr = sb.pool_base + 32'(span) - 1;
						if (pick == 2) addr = sb.pool_base + 32'(span);
						send_request(MODE_FREE, SIZE_W'($urandom), addr, outcome);
					end
				endcase
			end
			if (outcome.status == ST_ALLOCATED) live_blocks.push_back(outcome.block_address);
		end
	endtask

	initial begin
		alloc_result_t     outcome;
		logic [ADDR_W-1:0] base;
		sb = new();
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		req_ch.valid           = 1'b0;
		req_ch.mode            = MODE_ALLOC;
		req_ch.request_size    = '0;
		req_ch.release_address = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		settings_run++;
		send_request(MODE_ALLOC, 16'd16, '0, outcome);
		send_request(MODE_ALLOC, 16'd0, $urandom, outcome);
		send_request(MODE_ALLOC, 16'hFFFF, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd17, 32'hFFFF_FFFF, outcome);
		send_request(MODE_FREE, 16'hFFFF, 32'd0, outcome);
		send_request(MODE_FREE, 16'd0, 32'hFFFF_FFFF, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4095, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd8192, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd8191, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4096, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);

		program_pool(16'd16, 9'd2, 32'd4096);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4096, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4112, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4100, outcome);
		send_request(MODE_ALLOC, 16'd32, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd16, $urandom, outcome);
		send_request(MODE_FREE, SIZE_W'($urandom), 32'd4128, outcome);
		drain_responses();
		write_register(REG_BLOCK_SIZE, 32'd8);
		settings_run++;
		send_request(MODE_ALLOC, 16'd8, $urandom, outcome);
		send_request(MODE_ALLOC, 16'd8, $urandom, outcome);

		program_pool(16'd16, 9'd256, 32'h0001_0000);
		run_random(350, 70, 20, -1, 1'b0);
		program_pool(16'hFFFF, 9'd256, 32'hFFFF_0000);
		run_random(60, 50, 30, -1, 1'b0);
		program_pool(16'd1, 9'd1, 32'd1);
		run_random(60, 45, 35, -1, 1'b0);
		program_pool(16'd1, 9'd0, 32'hFFFF_FFFF);
		run_random(40, 45, 35, -1, 1'b0);
		program_pool(16'd24, 9'd511, 32'h8000_0000);
		run_random(200, 60, 25, -1, 1'b1);
		base = $urandom;
		if (base == '0) base = 32'd1;
		program_pool(16'd7, 9'd40, base);
		steady = 1'b1;
		run_random(200, 50, 35, 100, 1'b0);
		steady = 1'b0;
		program_pool(16'd16, 9'd8, 32'd0);
		run_random(40, 45, 35, -1, 1'b0);
		base = $urandom;
		if (base == '0) base = 32'd1;
		program_pool(SIZE_W'($urandom_range(300, 1)), COUNT_W'($urandom_range(256, 1)), base);
		run_random(150, 50, 35, -1, 1'b0);

		drain_responses();
		repeat (20) @(posedge clk);
		$display("Run covered %0d requests and %0d response words under %0d pool settings.",
			sb.requests, sb.responses, settings_run);
		$display("Outcomes: alloc %0d, size refused %0d, exhausted %0d, freed %0d, %s %0d, %s %0d, %s %0d",
			sb.outcome_count[ST_ALLOCATED], sb.outcome_count[ST_MISMATCH],
			sb.outcome_count[ST_EXHAUSTED], sb.outcome_count[ST_FREED],
			"outside", sb.outcome_count[ST_OUTSIDE], "null", sb.outcome_count[ST_NULL],
			"stack full", sb.outcome_count[ST_FULL]);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
